// ----- rtl/core/mips_subset_executor_defines.svh -----
// Assertion macros for the MIPS subset executor.
// Used by the top level only; no other dependencies.
`ifndef MIPS_SUBSET_EXECUTOR_DEFINES_SVH
`define MIPS_SUBSET_EXECUTOR_DEFINES_SVH
// implication checked on every clock, disabled in reset
`define MSE_ASSERT_IMPLY(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");
// next-cycle implication
`define MSE_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");
`endif

// ----- rtl/core/mse_pkg.sv -----
// Shared types and constants for the MIPS subset executor.
// No dependencies.
package mse_pkg;
   localparam int MemWordsDefault = 262144;
   localparam logic [31:0] HaltPc  = 32'hFFFF_FFFF;
   localparam logic [31:0] SpReset = 32'h0010_0000;

   localparam logic [5:0] OpSpecial = 6'h00;
   localparam logic [5:0] OpJ     = 6'h02;
   localparam logic [5:0] OpJal   = 6'h03;
   localparam logic [5:0] OpBeq   = 6'h04;
   localparam logic [5:0] OpBne   = 6'h05;
   localparam logic [5:0] OpAddi  = 6'h08;
   localparam logic [5:0] OpAddiu = 6'h09;
   localparam logic [5:0] OpSlti  = 6'h0A;
   localparam logic [5:0] OpSltiu = 6'h0B;
   localparam logic [5:0] OpAndi  = 6'h0C;
   localparam logic [5:0] OpOri   = 6'h0D;
   localparam logic [5:0] OpLui   = 6'h0F;
   localparam logic [5:0] OpLw    = 6'h23;
   localparam logic [5:0] OpSw    = 6'h2B;
   localparam logic [5:0] OpLl    = 6'h30;

   localparam logic [5:0] FnSll  = 6'h00;
   localparam logic [5:0] FnSrl  = 6'h02;
   localparam logic [5:0] FnJr   = 6'h08;
   localparam logic [5:0] FnAdd  = 6'h20;
   localparam logic [5:0] FnAddu = 6'h21;
   localparam logic [5:0] FnSub  = 6'h22;
   localparam logic [5:0] FnSubu = 6'h23;
   localparam logic [5:0] FnAnd  = 6'h24;
   localparam logic [5:0] FnOr   = 6'h25;
   localparam logic [5:0] FnNor  = 6'h27;
   localparam logic [5:0] FnSlt  = 6'h2A;
   localparam logic [5:0] FnSltu = 6'h2B;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_LOAD
   } state_type;

   // result word handed to the output register
   typedef struct packed {
      logic [31:0] pc_after;
      logic        halted;
      logic        reg_written;
      logic [4:0]  reg_index;
      logic [31:0] reg_value;
      logic        mem_written;
   } rsp_type;
endpackage

// ----- rtl/core/mse_memory.sv -----
// Word memory for program and data, one port, registered read.
// Depends on mse_pkg.
module mse_memory
   import mse_pkg::*;
#(
   parameter int MEM_WORDS = MemWordsDefault,
   localparam int AW = $clog2(MEM_WORDS)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] addr,
   input  logic [31:0]   wr_data,
   output logic [31:0]   rd_data
);
   logic [31:0] mem [MEM_WORDS];
   logic [31:0] rd_data_ff;

   // write or read at one address
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end
   assign rd_data = rd_data_ff;
endmodule

// ----- rtl/core/mse_regfile.sv -----
// General register file with reset values, two read ports, one write.
// Depends on mse_pkg.
module mse_regfile
   import mse_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [4:0]  rs,
   input  logic [4:0]  rt,
   output logic [31:0] a,
   output logic [31:0] b,
   input  logic        wr_en,
   input  logic [4:0]  wr_idx,
   input  logic [31:0] wr_data
);
   logic [31:0] regs_ff [32];

   // 32 registers, reset to the boot values
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 32; i++) begin
            regs_ff[i] <= '0;
         end
         regs_ff[29] <= SpReset;
         regs_ff[31] <= HaltPc;
      end else if (wr_en && wr_idx != 5'd0) begin
         regs_ff[wr_idx] <= wr_data;
      end
   end
   assign a = regs_ff[rs];
   assign b = regs_ff[rt];
endmodule

// ----- rtl/core/mse_execute.sv -----
// Instruction decode and execute for one fetched word.
// Depends on mse_pkg.
module mse_execute
   import mse_pkg::*;
(
   input  logic [31:0] pc,
   input  logic [31:0] instr,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic [31:0] next_pc,
   output logic        wr,
   output logic [4:0]  dst,
   output logic [31:0] val,
   output logic        is_load,
   output logic        is_store,
   output logic [31:0] mem_addr
);
   logic [5:0]  op, fn;
   logic [4:0]  rt, rd, sh;
   logic [31:0] zimm, simm, pc4, jt;

   assign op   = instr[31:26];
   assign rt   = instr[20:16];
   assign rd   = instr[15:11];
   assign sh   = instr[10:6];
   assign fn   = instr[5:0];
   assign zimm = {16'd0, instr[15:0]};
   assign simm = {{16{instr[15]}}, instr[15:0]};
   assign pc4  = pc + 32'd4;
   assign jt   = {pc4[31:28], instr[25:0], 2'b00};
   assign mem_addr = a + simm;

   // decode and compute
   always_comb begin
      logic        w;
      logic [4:0]  d;
      logic [31:0] v;
      w = 1'b0; d = 5'd0; v = '0;
      next_pc = pc4; is_load = 1'b0; is_store = 1'b0;
      case (op)
         OpSpecial: begin
            w = 1'b1; d = rd;
            case (fn)
               FnSll: v = b << sh;
               FnSrl: v = b >> sh;
               FnJr: begin w = 1'b0; next_pc = a; end
               FnAdd, FnAddu: v = a + b;
               FnSub, FnSubu: v = a - b;
               FnAnd: v = a & b;
               FnOr:  v = a | b;
               FnNor: v = ~(a | b);
               FnSlt: v = {31'd0, $signed(a) < $signed(b)};
               FnSltu: v = {31'd0, a < b};
               default: w = 1'b0;
            endcase
         end
         OpJ: next_pc = jt;
         OpJal: begin w = 1'b1; d = 5'd31; v = pc + 32'd8; next_pc = jt; end
         OpBeq: if (a == b) next_pc = pc4 + {simm[29:0], 2'b00};
         OpBne: if (a != b) next_pc = pc4 + {simm[29:0], 2'b00};
         OpAddi, OpAddiu: begin w = 1'b1; d = rt; v = a + simm; end
         OpSlti: begin w = 1'b1; d = rt; v = {31'd0, $signed(a) < $signed(simm)}; end
         OpSltiu: begin w = 1'b1; d = rt; v = {31'd0, a < simm}; end
         OpAndi: begin w = 1'b1; d = rt; v = a & zimm; end
         OpOri:  begin w = 1'b1; d = rt; v = a | zimm; end
         OpLui:  begin w = 1'b1; d = rt; v = {instr[15:0], 16'd0}; end
         OpLw, OpLl: begin w = 1'b1; d = rt; is_load = 1'b1; end
         OpSw: is_store = 1'b1;
         default: ;
      endcase
      if (d == 5'd0) begin
         w = 1'b0;
         is_load = 1'b0;
      end
      if (!w) begin
         d = 5'd0; v = '0;
      end
      wr = w; dst = d; val = v;
   end
endmodule

// ----- rtl/core/mips_subset_executor.sv -----
// MIPS subset executor: preload and step words, one result per item.
// A preload writes its word when taken; a step fetches, then executes; a load
// step fetches, executes, then reads data. One preload per cycle while the spare
// slot is empty; no item is taken while a step runs. Fetch and data share one memory port.
// Synchronous reset clears pc to zero and sets the register file to zero,
// r29 = 0x100000, r31 = 0xFFFFFFFF; memory is not cleared. A spare slot behind
// the output register lets the next word enter while one result waits.
`include "mips_subset_executor_defines.svh"
module mips_subset_executor
   import mse_pkg::*;
#(
   parameter int MEM_WORDS = MemWordsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [17:0] req_word_addr,
   input  logic [31:0] req_word_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_pc_after,
   output logic        rsp_halted,
   output logic        rsp_reg_written,
   output logic [4:0]  rsp_reg_index,
   output logic [31:0] rsp_reg_value,
   output logic        rsp_mem_written
);
   localparam int AW = $clog2(MEM_WORDS);

   state_type   state_ff, state_in;
   logic [31:0] pc_ff, pc_in;
   rsp_type     rsp_ff, rsp_in, pend_ff, pend_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     skid_ff, skid_in, done_rsp;
   logic        skid_valid_ff, skid_valid_in, done_valid;

   logic          mem_we;
   logic [AW-1:0] mem_addr;
   logic [31:0]   mem_wdata, mem_rdata;

   logic [31:0] a, b, next_pc, val, ex_addr;
   logic [4:0]  dst;
   logic        wr, is_load, is_store;
   logic        rf_we;
   logic [4:0]  rf_idx;
   logic [31:0] rf_data;
   logic        accept;

   mse_memory #(.MEM_WORDS(MEM_WORDS)) u_mem (
      .clock(clock), .wr_en(mem_we), .addr(mem_addr),
      .wr_data(mem_wdata), .rd_data(mem_rdata)
   );

   mse_regfile u_rf (
      .clock(clock), .reset(reset), .rs(mem_rdata[25:21]), .rt(mem_rdata[20:16]),
      .a(a), .b(b), .wr_en(rf_we), .wr_idx(rf_idx), .wr_data(rf_data)
   );

   mse_execute u_ex (
      .pc(pc_ff), .instr(mem_rdata), .a(a), .b(b), .next_pc(next_pc),
      .wr(wr), .dst(dst), .val(val), .is_load(is_load), .is_store(is_store),
      .mem_addr(ex_addr)
   );

   // one item in flight; its result always finds the spare slot empty
   assign req_ready = (state_ff == ST_IDLE) && !skid_valid_ff;
   assign accept    = req_valid && req_ready;

   // sequencer: memory port, register write and result
   always_comb begin
      state_in = state_ff; pc_in = pc_ff;
      pend_in = pend_ff;
      done_rsp = '0; done_valid = 1'b0;
      mem_we = 1'b0; mem_wdata = req_word_data;
      mem_addr = pc_ff[AW+1:2];
      rf_we = 1'b0; rf_idx = dst; rf_data = val;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_kind) begin
                  mem_we = 1'b1;
                  mem_addr = AW'(req_word_addr % MEM_WORDS);
                  done_rsp.pc_after = pc_ff;
                  done_rsp.mem_written = 1'b1;
                  done_valid = 1'b1;
               end else if (pc_ff == HaltPc) begin
                  done_rsp.pc_after = HaltPc;
                  done_rsp.halted = 1'b1;
                  done_valid = 1'b1;
               end else begin
                  state_in = ST_EXEC;
               end
            end
         end
         ST_EXEC: begin
            pend_in = '0;
            pend_in.pc_after = next_pc;
            pend_in.reg_written = wr;
            pend_in.reg_index = dst;
            pend_in.reg_value = val;
            pend_in.mem_written = is_store;
            pc_in = next_pc;
            mem_addr = ex_addr[AW+1:2];
            mem_wdata = b;
            mem_we = is_store;
            if (is_load) begin
               state_in = ST_LOAD;
            end else begin
               rf_we = wr;
               done_rsp = pend_in;
               done_valid = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_LOAD: begin
            rf_we = 1'b1; rf_idx = pend_ff.reg_index; rf_data = mem_rdata;
            done_rsp = pend_ff;
            done_rsp.reg_value = mem_rdata;
            done_valid = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // output register with one spare slot behind it, oldest word first
   always_comb begin
      rsp_in = rsp_ff; rsp_valid_in = rsp_valid_ff;
      skid_in = skid_ff; skid_valid_in = skid_valid_ff;
      if (!rsp_valid_ff || rsp_ready) begin
         if (skid_valid_ff) begin
            rsp_in = skid_ff; rsp_valid_in = 1'b1;
            skid_in = done_rsp; skid_valid_in = done_valid;
         end else begin
            rsp_in = done_rsp; rsp_valid_in = done_valid;
         end
      end else if (done_valid) begin
         skid_in = done_rsp; skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pc_ff <= '0;
         rsp_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pc_ff <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      rsp_ff <= rsp_in;
      skid_ff <= skid_in;
      pend_ff <= pend_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pc_after    = rsp_ff.pc_after;
   assign rsp_halted      = rsp_ff.halted;
   assign rsp_reg_written = rsp_ff.reg_written;
   assign rsp_reg_index   = rsp_ff.reg_index;
   assign rsp_reg_value   = rsp_ff.reg_value;
   assign rsp_mem_written = rsp_ff.mem_written;

   `MSE_ASSERT_IMPLY(a_no_accept_busy, clock, reset, state_ff != ST_IDLE, !req_ready)
   `MSE_ASSERT_IMPLY(a_r0_never, clock, reset, rsp_valid && rsp_reg_written, rsp_reg_index != 5'd0)
   `MSE_ASSERT_IMPLY(a_halt_quiet, clock, reset, rsp_valid && rsp_halted, !rsp_reg_written && !rsp_mem_written)
   `MSE_ASSERT_NEXT(a_exec_done, clock, reset, state_ff == ST_LOAD, state_ff == ST_IDLE && rsp_valid)
endmodule
